### hdl/weighted_round_robin_chunk_distributor_top_macros.svh
// Assertion macros shared by the weighted round-robin distributor RTL.
`ifndef WEIGHTED_ROUND_ROBIN_CHUNK_DISTRIBUTOR_TOP_MACROS_SVH
`define WEIGHTED_ROUND_ROBIN_CHUNK_DISTRIBUTOR_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define WRR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define WRR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/wrrcd_pkg.sv
// Package with the codes, field widths and default sizes of the work distributor.
package wrrcd_pkg;

	// Default sizes handed to the top-level parameters.
	localparam int DEF_MAX_DEVICES = 8;
	localparam int DEF_MAX_ITEMS   = 4096;

	// Fixed widths of the ports.
	localparam int OP_W      = 2;
	localparam int DEVICE_W  = 3;
	localparam int SCORE_W   = 16;
	localparam int COUNT_W   = 13;
	localparam int STATUS_W  = 2;
	localparam int SLOT_W    = 12;
	localparam int ID_W      = 12;
	localparam int INUSE_W   = 4;
	localparam int DEVCNT_W  = 4;
	localparam int CHUNK_W   = 13;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 13;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
	localparam logic [OP_W-1:0] OP_BEGIN = 2'd1;
	localparam logic [OP_W-1:0] OP_NEXT  = 2'd2;
	localparam logic [OP_W-1:0] OP_NONE  = 2'd3;

	// Result status codes.
	localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NONE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_OVER = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_DEV_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CHUNK     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MODE      = 2'd2;

	// Distribution modes.
	localparam logic MODE_ROUND_ROBIN = 1'b0;
	localparam logic MODE_CONTIGUOUS  = 1'b1;

endpackage

### hdl/weighted_round_robin_chunk_distributor_top.sv
// Weighted round-robin distributor of numbered work items over a set of devices.
//
// The block takes one command transaction at a time: start is sampled while busy is low,
// and every command except the unused code 3 answers with exactly one result transaction,
// shown on the result ports for a single cycle while done is high. The receiver cannot
// stall, so it must take every result in the cycle it appears. A weight load answers in the
// cycle after it is taken. A begin whose count does not exceed the device count also answers
// in the cycle after it is taken. Otherwise begin runs a sequencer over the devices with one
// shared 16-bit by count-width multiplier, a multiply state and an accumulate state per
// device, then checks the quota sum, then runs the shared restoring divider (one quotient bit
// per cycle) to split the remainder, and spreads it in a single spread state, with dev_count
// clamped to 1..8. A next command scans the devices for one with room, one device per cycle
// starting at the current device, then in round-robin mode runs the same divider to test
// whether the following id lands on a chunk boundary, and finishes with an update state.
// A next command with nothing pending answers in the cycle after it is taken. Configuration
// writes are always ready and take effect at once; they must only be issued while the block
// is idle. Quotas and the active device count are fixed at begin, while mode and the chunk
// length are read on every next command.
`include "weighted_round_robin_chunk_distributor_top_macros.svh"

module weighted_round_robin_chunk_distributor_top
	import wrrcd_pkg::*;
#(
	parameter int MAX_DEVICES = DEF_MAX_DEVICES,
	parameter int MAX_ITEMS   = DEF_MAX_ITEMS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// Command channel.
	input  logic                 start,
	output logic                 busy,
	input  logic [OP_W-1:0]      operation,
	input  logic [DEVICE_W-1:0]  device,
	input  logic [SCORE_W-1:0]   score,
	input  logic [COUNT_W-1:0]   count,
	// Result channel.
	output logic                 done,
	output logic [STATUS_W-1:0]  status,
	output logic [DEVICE_W-1:0]  dest_device,
	output logic [SLOT_W-1:0]    slot,
	output logic [ID_W-1:0]      item_id,
	output logic [INUSE_W-1:0]   devices_in_use,
	output logic                 final_res,
	// Configuration write channel.
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data
);

	// Index of a device, count of devices, count of items and their derived widths.
	localparam int DEV_W   = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
	localparam int DCNT_W  = $clog2(MAX_DEVICES + 1);
	localparam int CNT_W   = $clog2(MAX_ITEMS + 1);
	localparam int SUM_W   = CNT_W + DCNT_W;
	localparam int PROD_W  = SCORE_W + CNT_W;
	localparam int DIV_W   = CHUNK_W;
	localparam int DCTR_W  = $clog2(CNT_W);

	// Sequencer states.
	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_MUL    = 4'd1;
	localparam logic [3:0] S_ACC    = 4'd2;
	localparam logic [3:0] S_CHECK  = 4'd3;
	localparam logic [3:0] S_DIV    = 4'd4;
	localparam logic [3:0] S_SPREAD = 4'd5;
	localparam logic [3:0] S_SCAN   = 4'd6;
	localparam logic [3:0] S_UPDATE = 4'd7;

	logic [3:0] state_q;

	// Configuration registers.
	logic [DEVCNT_W-1:0] dev_count_q;
	logic [CHUNK_W-1:0]  chunk_len_q;
	logic                mode_q;

	// Distribution state.
	logic [SCORE_W-1:0] weight_q [MAX_DEVICES];
	logic [CNT_W-1:0]   quota_q  [MAX_DEVICES];
	logic [CNT_W-1:0]   fill_q   [MAX_DEVICES];
	logic [CNT_W-1:0]   next_id_q;
	logic [CNT_W-1:0]   total_q;
	logic [DEV_W-1:0]   cur_dev_q;
	logic               running_q;
	logic [DCNT_W-1:0]  active_q;

	// Working registers of the begin and next sequences.
	logic [CNT_W-1:0]   cnt_q;
	logic [DCNT_W-1:0]  n_q;
	logic [DEV_W-1:0]   ptr_q;
	logic [DEV_W-1:0]   scan_k_q;
	logic [DEV_W-1:0]   dev_q;
	logic [SUM_W-1:0]   sum_q;
	logic [PROD_W-1:0]  prod_q;

	// Shared restoring divider: dividend shifts out and quotient shifts in.
	logic [CNT_W-1:0]   dvd_q;
	logic [DIV_W-1:0]   dsr_q;
	logic [DIV_W-1:0]   rem_q;
	logic [DCTR_W-1:0]  div_ctr_q;
	logic               div_for_next_q;

	// Result registers.
	logic                done_q;
	logic [STATUS_W-1:0] status_q;
	logic [DEVICE_W-1:0] dest_device_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [ID_W-1:0]     item_id_q;
	logic [INUSE_W-1:0]  in_use_q;
	logic                final_q;

	// Combinational helpers.
	logic [DEVICE_W:0]   widx_full;
	logic [DEV_W-1:0]    widx;
	logic [CNT_W-1:0]    cnt_sat;
	logic [DCNT_W-1:0]   n_clamp;
	logic [DIV_W:0]      div_cand;
	logic                div_ge;
	logic [DIV_W:0]      div_diff;
	logic [CNT_W-1:0]    fill_sel;
	logic [CNT_W-1:0]    quota_sel;
	logic [CNT_W-1:0]    fill_inc;
	logic [CNT_W-1:0]    id_inc;
	logic [DEV_W-1:0]    dev_wrap;
	logic                stay_dev;
	logic [DCNT_W+INUSE_W-1:0] act_pad;
	logic [CNT_W+INUSE_W-1:0]  cnt_pad;
	logic [CNT_W+SLOT_W-1:0]   slot_pad;
	logic [CNT_W+ID_W-1:0]     id_pad;
	logic [DEV_W+DEVICE_W-1:0] dev_pad;

	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;

	// A weight load folds the device number into the table by repeated subtraction.
	always_comb begin
		widx_full = {1'b0, device};
		for (int i = 0; i < 8; i++) begin
			if (32'(widx_full) >= MAX_DEVICES) begin
				widx_full = widx_full - (DEVICE_W + 1)'(MAX_DEVICES);
			end
		end
		widx = DEV_W'(widx_full);
	end

	// Saturated item count and clamped device count used by begin.
	always_comb begin
		if (32'(count) > MAX_ITEMS) begin
			cnt_sat = CNT_W'(MAX_ITEMS);
		end else begin
			cnt_sat = CNT_W'(count);
		end
		if (dev_count_q == '0) begin
			n_clamp = DCNT_W'(1);
		end else if (32'(dev_count_q) > MAX_DEVICES) begin
			n_clamp = DCNT_W'(MAX_DEVICES);
		end else begin
			n_clamp = DCNT_W'(dev_count_q);
		end
	end

	// One step of the divider.
	always_comb begin
		div_cand = {rem_q, dvd_q[CNT_W-1]};
		div_ge   = (div_cand >= {1'b0, dsr_q});
		div_diff = div_cand - {1'b0, dsr_q};
	end

	// Bookkeeping for the device chosen by a next command.
	always_comb begin
		fill_sel  = fill_q[dev_q];
		quota_sel = quota_q[dev_q];
		fill_inc  = fill_sel + CNT_W'(1);
		id_inc    = next_id_q + CNT_W'(1);
		if (32'(dev_q) + 1 == 32'(active_q)) begin
			dev_wrap = '0;
		end else begin
			dev_wrap = dev_q + DEV_W'(1);
		end
		if (mode_q == MODE_CONTIGUOUS) begin
			stay_dev = 1'b1;
		end else begin
			stay_dev = (rem_q != '0) && (fill_inc < quota_sel);
		end
	end

	// Port-width views of internal values; the model keeps the low bits.
	assign act_pad  = {{INUSE_W{1'b0}}, active_q};
	assign cnt_pad  = {{INUSE_W{1'b0}}, cnt_sat};
	assign slot_pad = {{SLOT_W{1'b0}}, fill_sel};
	assign id_pad   = {{ID_W{1'b0}}, next_id_q};
	assign dev_pad  = {{DEVICE_W{1'b0}}, dev_q};

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_count_q <= DEVCNT_W'(1);
			chunk_len_q <= CHUNK_W'(1);
			mode_q      <= MODE_ROUND_ROBIN;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_DEV_COUNT: dev_count_q <= cfg_data[DEVCNT_W-1:0];
				REG_CHUNK:     chunk_len_q <= cfg_data[CHUNK_W-1:0];
				REG_MODE:      mode_q      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Sequencer, tables and result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			next_id_q      <= '0;
			total_q        <= '0;
			cur_dev_q      <= '0;
			running_q      <= 1'b0;
			active_q       <= '0;
			done_q         <= 1'b0;
			div_for_next_q <= 1'b0;
			for (int d = 0; d < MAX_DEVICES; d++) begin
				weight_q[d] <= '0;
				quota_q[d]  <= '0;
				fill_q[d]   <= '0;
			end
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						case (operation)
							OP_LOAD: begin
								weight_q[widx] <= score;
								done_q         <= 1'b1;
								status_q       <= ST_OK;
								dest_device_q  <= '0;
								slot_q         <= '0;
								item_id_q      <= '0;
								in_use_q       <= '0;
								final_q        <= 1'b0;
							end
							OP_BEGIN: begin
								cnt_q     <= cnt_sat;
								n_q       <= n_clamp;
								next_id_q <= '0;
								cur_dev_q <= '0;
								for (int d = 0; d < MAX_DEVICES; d++) begin
									fill_q[d] <= '0;
								end
								if (32'(cnt_sat) <= 32'(n_clamp)) begin
									// Few items: one per device from device zero up.
									for (int d = 0; d < MAX_DEVICES; d++) begin
										quota_q[d] <= (d < 32'(cnt_sat)) ? CNT_W'(1) : '0;
									end
									active_q      <= DCNT_W'(cnt_sat);
									total_q       <= cnt_sat;
									running_q     <= 1'b1;
									done_q        <= 1'b1;
									status_q      <= ST_OK;
									dest_device_q <= '0;
									slot_q        <= '0;
									item_id_q     <= '0;
									in_use_q      <= cnt_pad[INUSE_W-1:0];
									final_q       <= 1'b0;
								end else begin
									active_q <= n_clamp;
									ptr_q    <= '0;
									sum_q    <= '0;
									state_q  <= S_MUL;
								end
							end
							OP_NEXT: begin
								if (!running_q || next_id_q >= total_q || active_q == '0) begin
									done_q        <= 1'b1;
									status_q      <= ST_NONE;
									dest_device_q <= '0;
									slot_q        <= '0;
									item_id_q     <= '0;
									in_use_q      <= '0;
									final_q       <= 1'b0;
								end else begin
									ptr_q    <= cur_dev_q;
									scan_k_q <= '0;
									state_q  <= S_SCAN;
								end
							end
							default: ;
						endcase
					end
				end
				S_MUL: begin
					prod_q  <= PROD_W'(weight_q[ptr_q]) * PROD_W'(cnt_q);
					state_q <= S_ACC;
				end
				S_ACC: begin
					quota_q[ptr_q] <= prod_q[SCORE_W +: CNT_W];
					sum_q          <= sum_q + SUM_W'(prod_q[SCORE_W +: CNT_W]);
					if (32'(ptr_q) + 1 == 32'(n_q)) begin
						state_q <= S_CHECK;
					end else begin
						ptr_q   <= ptr_q + DEV_W'(1);
						state_q <= S_MUL;
					end
				end
				S_CHECK: begin
					if (sum_q > SUM_W'(cnt_q)) begin
						// Floored quotas already overshoot the count: abandon the run.
						for (int d = 0; d < MAX_DEVICES; d++) begin
							quota_q[d] <= '0;
						end
						active_q      <= '0;
						total_q       <= '0;
						running_q     <= 1'b0;
						done_q        <= 1'b1;
						status_q      <= ST_OVER;
						dest_device_q <= '0;
						slot_q        <= '0;
						item_id_q     <= '0;
						in_use_q      <= '0;
						final_q       <= 1'b0;
						state_q       <= S_IDLE;
					end else begin
						dvd_q          <= cnt_q - CNT_W'(sum_q);
						dsr_q          <= DIV_W'(n_q);
						rem_q          <= '0;
						div_ctr_q      <= DCTR_W'(CNT_W - 1);
						div_for_next_q <= 1'b0;
						state_q        <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_ge) begin
						rem_q <= div_diff[DIV_W-1:0];
					end else begin
						rem_q <= div_cand[DIV_W-1:0];
					end
					dvd_q <= {dvd_q[CNT_W-2:0], div_ge};
					if (div_ctr_q == '0) begin
						state_q <= div_for_next_q ? S_UPDATE : S_SPREAD;
					end else begin
						div_ctr_q <= div_ctr_q - DCTR_W'(1);
					end
				end
				S_SPREAD: begin
					// The remainder goes out evenly, the leftover to the lowest devices.
					for (int d = 0; d < MAX_DEVICES; d++) begin
						if (d < 32'(n_q)) begin
							quota_q[d] <= quota_q[d] + dvd_q
								+ ((d < 32'(rem_q)) ? CNT_W'(1) : CNT_W'(0));
						end
					end
					total_q       <= cnt_q;
					running_q     <= 1'b1;
					done_q        <= 1'b1;
					status_q      <= ST_OK;
					dest_device_q <= '0;
					slot_q        <= '0;
					item_id_q     <= '0;
					in_use_q      <= act_pad[INUSE_W-1:0];
					final_q       <= 1'b0;
					state_q       <= S_IDLE;
				end
				S_SCAN: begin
					if (fill_q[ptr_q] < quota_q[ptr_q]) begin
						dev_q <= ptr_q;
						if (mode_q == MODE_ROUND_ROBIN) begin
							// Remainder of the following id by the chunk length.
							dvd_q          <= id_inc;
							dsr_q          <= (chunk_len_q == '0) ? DIV_W'(1) : chunk_len_q;
							rem_q          <= '0;
							div_ctr_q      <= DCTR_W'(CNT_W - 1);
							div_for_next_q <= 1'b1;
							state_q        <= S_DIV;
						end else begin
							state_q <= S_UPDATE;
						end
					end else if (32'(scan_k_q) + 1 >= 32'(active_q)) begin
						done_q        <= 1'b1;
						status_q      <= ST_NONE;
						dest_device_q <= '0;
						slot_q        <= '0;
						item_id_q     <= '0;
						in_use_q      <= '0;
						final_q       <= 1'b0;
						state_q       <= S_IDLE;
					end else begin
						scan_k_q <= scan_k_q + DEV_W'(1);
						if (32'(ptr_q) + 1 == 32'(active_q)) begin
							ptr_q <= '0;
						end else begin
							ptr_q <= ptr_q + DEV_W'(1);
						end
					end
				end
				S_UPDATE: begin
					fill_q[dev_q] <= fill_inc;
					next_id_q     <= id_inc;
					cur_dev_q     <= stay_dev ? dev_q : dev_wrap;
					done_q        <= 1'b1;
					status_q      <= ST_OK;
					dest_device_q <= dev_pad[DEVICE_W-1:0];
					slot_q        <= slot_pad[SLOT_W-1:0];
					item_id_q     <= id_pad[ID_W-1:0];
					in_use_q      <= act_pad[INUSE_W-1:0];
					final_q       <= (id_inc == total_q);
					state_q       <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done           = done_q;
	assign status         = status_q;
	assign dest_device    = dest_device_q;
	assign slot           = slot_q;
	assign item_id        = item_id_q;
	assign devices_in_use = in_use_q;
	assign final_res      = final_q;

	// A result only appears once the sequencer is back at rest.
	`WRR_ASSERT_NOW(a_done_idle, done, !busy, "result shown while busy")
	// Ids never run past the total of the current run.
	`WRR_ASSERT_NOW(a_id_bound, 1'b1, next_id_q <= total_q, "next id beyond total")
	// The scan pointer stays among the active devices.
	`WRR_ASSERT_NOW(a_scan_ptr, state_q == S_SCAN, 32'(ptr_q) < 32'(active_q),
		"scan pointer outside active devices")
	// The last item of a run leaves the id counter at the total.
	`WRR_ASSERT_NOW(a_final_total, done && final_res, next_id_q == total_q,
		"final item flagged before total reached")

endmodule
